// ===== rtl/core/awg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package awg_pkg;

  localparam logic [14:0] FULL_SCALE = 15'd32767;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DIV_NUM_W = 34;
  localparam int unsigned DIV_DEN_W = 16;

  typedef enum logic [2:0] {
    CFG_SHAPE   = 3'd0,
    CFG_PERIOD  = 3'd1,
    CFG_ATTACK  = 3'd2,
    CFG_DECAY   = 3'd3,
    CFG_SUSTAIN = 3'd4,
    CFG_RELEASE = 3'd5,
    CFG_NOTE    = 3'd6
  } awg_cfg_e;

  typedef enum logic [1:0] {
    SHAPE_SQUARE = 2'd0,
    SHAPE_SAW    = 2'd1,
    SHAPE_TRI    = 2'd2,
    SHAPE_SINE   = 2'd3
  } awg_shape_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ZERO,
    OP_PREP,
    OP_SUS,
    OP_MUL_A,
    OP_SUB_A,
    OP_MUL_D,
    OP_SUB_D,
    OP_ENV_S,
    OP_SUB_S,
    OP_MUL_R,
    OP_ENV_Z,
    OP_DIV_ENV,
    OP_ENV_SET,
    OP_DIV_T,
    OP_SET_T,
    OP_SQR,
    OP_MUL_W,
    OP_DIV_W,
    OP_SET_V,
    OP_MUL_SC,
    OP_SET_RES,
    OP_EMIT
  } awg_op_e;

  typedef struct packed {
    awg_op_e op;
  } awg_cmd_t;

  typedef struct packed {
    logic       active;
    logic       rel_lt_a;
    logic       rel_lt_d;
    logic       rel_lt_s;
    logic       rel_lt_r;
    logic       div_done;
    awg_shape_e shape;
  } awg_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/awg_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module awg_div
  import awg_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DIV_NUM_W-1:0] num_i,
  input  wire logic [DIV_DEN_W-1:0] den_i,
  output logic                      done_o,
  output logic [DIV_NUM_W-1:0]      quot_o,
  output logic [DIV_DEN_W-1:0]      rem_o
);

  localparam int unsigned CntW = $clog2(DIV_NUM_W + 1);

  logic [DIV_DEN_W-1:0] acc_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [CntW-1:0]      cnt_q;
  logic                 run_q;
  logic                 done_q;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W+1:0] diff;

  // one quotient bit per cycle, restoring
  assign shifted = {acc_q, quo_q[DIV_NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(DIV_NUM_W);
    end else if (run_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (run_q) begin
      if (!diff[DIV_DEN_W+1]) begin
        acc_q <= diff[DIV_DEN_W-1:0];
        quo_q <= {quo_q[DIV_NUM_W-2:0], 1'b1};
      end else begin
        acc_q <= shifted[DIV_DEN_W-1:0];
        quo_q <= {quo_q[DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = acc_q;

endmodule

`default_nettype wire

// ===== rtl/core/awg_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module awg_dp
  import awg_pkg::*;
#(
  parameter int unsigned IndexBits      = 20,
  parameter int unsigned SineTableDepth = 256
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  restart_i,
  input  wire awg_cmd_t              cmd_i,
  output awg_status_t                status_o,
  output logic signed [15:0]         sample_o,
  output logic                       note_active_o,
  output logic                       last_of_note_o
);

  localparam int unsigned IW = IndexBits;
  localparam int unsigned SW = (IndexBits > 18) ? IndexBits : 18;
  localparam int unsigned LutW = $clog2(SineTableDepth);
  // 32767 * ceil(2^29 / 100), exact floor of pct * 32767 / 100 after >> 29
  localparam logic [37:0] SusRecip = 38'd175916520570;

  // quarter-wave taylor series in q30, evaluated at elaboration
  function automatic longint quarter_sine(longint num);
    longint x;
    longint term;
    longint sum;
    x    = (num * 64'sd1686629713) / SineTableDepth;
    term = x;
    sum  = x;
    term = (((term * x) >>> 30) * x >>> 30) / 6;
    sum  = sum - term;
    term = (((term * x) >>> 30) * x >>> 30) / 20;
    sum  = sum + term;
    term = (((term * x) >>> 30) * x >>> 30) / 42;
    sum  = sum - term;
    term = (((term * x) >>> 30) * x >>> 30) / 72;
    sum  = sum + term;
    term = (((term * x) >>> 30) * x >>> 30) / 110;
    sum  = sum - term;
    term = (((term * x) >>> 30) * x >>> 30) / 156;
    sum  = sum + term;
    if (sum < 0) sum = 0;
    sum = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
    if (sum > 32767) sum = 32767;
    return sum;
  endfunction

  function automatic longint sine_entry(longint k);
    longint quad;
    longint rem;
    longint v;
    quad = (4 * k) / SineTableDepth;
    rem  = (4 * k) % SineTableDepth;
    v    = quarter_sine(quad[0] ? SineTableDepth - rem : rem);
    return (quad >= 2) ? -v : v;
  endfunction

  logic signed [15:0] sine_lut [SineTableDepth];

  for (genvar g = 0; g < SineTableDepth; g++) begin : g_lut
    assign sine_lut[g] = 16'(sine_entry(g));
  end

  typedef enum logic [1:0] {SECT_A, SECT_D, SECT_R} sect_e;

  // configuration
  awg_shape_e      shape_q;
  logic [15:0]     per_q, att_q, dec_q, rel_len_q;
  logic [6:0]      pct_q;
  logic [19:0]     note_q;

  // working registers
  logic [IW-1:0]   idx_q, n_q, rel_q, sus_q;
  logic            act_q;
  logic [17:0]     sum_q;
  logic [14:0]     s_q, env_q;
  logic [15:0]     den_q, t_q;
  sect_e           sect_q;
  logic signed [17:0] v_q;
  logic [31:0]     prod_q;
  logic signed [15:0] res_q;
  logic signed [15:0] smp_q;
  logic            oact_q, olast_q;

  logic [IW-1:0]   len;
  logic [6:0]      pct_c;
  logic [15:0]     per_c;
  logic [15:0]     mul_a, mul_b;
  logic            mul_en;
  logic            div_start;
  logic [DIV_NUM_W-1:0] div_num, quot;
  logic [DIV_DEN_W-1:0] div_den, rem;
  logic            div_done;
  logic [17:0]     q18;
  logic [14:0]     mag;
  logic [44:0]     sus_prod;
  logic [31:0]     scl_sum;

  assign len   = IW'(note_q);
  assign pct_c = (pct_q > 7'd100) ? 7'd100 : pct_q;
  assign per_c = (per_q < 16'd2) ? 16'd2 : per_q;
  assign q18   = quot[17:0];
  assign mag   = v_q[17] ? 15'(-v_q) : v_q[14:0];

  // sustain level by reciprocal multiply
  assign sus_prod = 45'(pct_c) * 45'(SusRecip);
  // gain scaling: floor(p / 32767) = (p + (p >> 15) + 1) >> 15 for p < 2^30
  assign scl_sum  = prod_q + {15'd0, prod_q[31:15]} + 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q   <= SHAPE_SQUARE;
      per_q     <= 16'd100;
      att_q     <= 16'd480;
      dec_q     <= 16'd480;
      pct_q     <= 7'd50;
      rel_len_q <= 16'd480;
      note_q    <= 20'd2400;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SHAPE:   shape_q   <= awg_shape_e'(cfg_data_i[1:0]);
        CFG_PERIOD:  per_q     <= cfg_data_i[15:0];
        CFG_ATTACK:  att_q     <= cfg_data_i[15:0];
        CFG_DECAY:   dec_q     <= cfg_data_i[15:0];
        CFG_SUSTAIN: pct_q     <= cfg_data_i[6:0];
        CFG_RELEASE: rel_len_q <= cfg_data_i[15:0];
        CFG_NOTE:    note_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.op == OP_LOAD && restart_i) begin
      idx_q <= '0;
    end else if (cmd_i.op == OP_EMIT && act_q) begin
      idx_q <= n_q + 1'b1;
    end
  end

  // multiplier operand select, product registered
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (cmd_i.op)
      OP_MUL_A:  begin mul_a = rel_q[15:0];    mul_b = 16'(FULL_SCALE); end
      OP_MUL_D:  begin mul_a = rel_q[15:0];    mul_b = 16'(FULL_SCALE - s_q); end
      OP_MUL_R:  begin mul_a = rel_q[15:0];    mul_b = 16'(s_q); end
      OP_MUL_W:  begin
        mul_a = t_q;
        mul_b = (shape_q == SHAPE_SINE) ? 16'(SineTableDepth) : 16'(FULL_SCALE);
      end
      OP_MUL_SC: begin mul_a = 16'(env_q);     mul_b = 16'(mag); end
      default:   mul_en = 1'b0;
    endcase
  end

  always_comb begin
    div_start = 1'b1;
    div_num   = DIV_NUM_W'(prod_q);
    div_den   = den_q;
    unique case (cmd_i.op)
      OP_DIV_ENV: div_den = den_q;
      OP_DIV_T:   begin div_num = DIV_NUM_W'(n_q); div_den = per_c; end
      OP_DIV_W:   begin
        div_den = per_c;
        unique case (shape_q)
          SHAPE_SAW: div_num = DIV_NUM_W'(prod_q) << 1;
          SHAPE_TRI: div_num = DIV_NUM_W'(prod_q) << 2;
          default:   div_num = DIV_NUM_W'(prod_q);
        endcase
      end
      default:    div_start = 1'b0;
    endcase
  end

  awg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (quot),
    .rem_o  (rem)
  );

  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= mul_a * mul_b;
    unique case (cmd_i.op)
      OP_LOAD: n_q <= restart_i ? '0 : idx_q;
      OP_ZERO: begin
        act_q <= 1'b0;
        res_q <= '0;
      end
      OP_PREP: begin
        act_q <= 1'b1;
        rel_q <= n_q;
        sum_q <= 18'(att_q) + 18'(dec_q) + 18'(rel_len_q);
        s_q   <= sus_prod[43:29];
      end
      OP_SUS: sus_q <= (SW'(len) > SW'(sum_q)) ? IW'(SW'(len) - SW'(sum_q)) : '0;
      OP_MUL_A: begin den_q <= att_q;     sect_q <= SECT_A; end
      OP_MUL_D: begin den_q <= dec_q;     sect_q <= SECT_D; end
      OP_MUL_R: begin den_q <= rel_len_q; sect_q <= SECT_R; end
      OP_SUB_A: rel_q <= rel_q - IW'(att_q);
      OP_SUB_D: rel_q <= rel_q - IW'(dec_q);
      OP_SUB_S: rel_q <= rel_q - sus_q;
      OP_ENV_S: env_q <= s_q;
      OP_ENV_Z: env_q <= '0;
      OP_ENV_SET: begin
        unique case (sect_q)
          SECT_A:  env_q <= quot[14:0];
          SECT_D:  env_q <= FULL_SCALE - quot[14:0];
          default: env_q <= s_q - quot[14:0];
        endcase
      end
      OP_SET_T: t_q <= rem;
      OP_SQR: res_q <= (t_q < (per_c >> 1)) ? 16'(env_q) : -16'(env_q);
      OP_SET_V: begin
        unique case (shape_q)
          SHAPE_SAW: v_q <= (q18 >= 18'(FULL_SCALE)) ? $signed(q18 - 18'd65534)
                                                     : $signed(q18);
          SHAPE_TRI: begin
            if (q18 < 18'(FULL_SCALE)) v_q <= $signed(q18);
            else if (q18 < 18'd98301) v_q <= $signed(18'd65534 - q18);
            else v_q <= $signed(q18 - 18'd131068);
          end
          default: v_q <= 18'(sine_lut[quot[LutW-1:0]]);
        endcase
      end
      OP_SET_RES: res_q <= v_q[17] ? -16'(scl_sum[29:15]) : 16'(scl_sum[29:15]);
      OP_EMIT: begin
        smp_q   <= res_q;
        oact_q  <= act_q;
        olast_q <= act_q && (({1'b0, n_q} + 1'b1) == {1'b0, len});
      end
      default: ;
    endcase
  end

  assign status_o.active   = n_q < len;
  assign status_o.rel_lt_a = rel_q < IW'(att_q);
  assign status_o.rel_lt_d = rel_q < IW'(dec_q);
  assign status_o.rel_lt_s = rel_q < sus_q;
  assign status_o.rel_lt_r = rel_q < IW'(rel_len_q);
  assign status_o.div_done = div_done;
  assign status_o.shape    = shape_q;

  assign sample_o       = smp_q;
  assign note_active_o  = oact_q;
  assign last_of_note_o = olast_q;

endmodule

`default_nettype wire

// ===== rtl/core/awg_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module awg_ctrl
  import awg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  input  wire awg_status_t status_i,
  output awg_cmd_t         cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHK, ST_SUS, ST_EA, ST_ED, ST_ES, ST_ER, ST_EMUL, ST_EWAIT,
    ST_TDIV, ST_TWAIT, ST_WAVE, ST_WDIV, ST_WWAIT, ST_SMUL, ST_SDIV,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) begin cmd_o.op = OP_LOAD; state_d = ST_CHK; end
      ST_CHK: begin
        if (status_i.active) begin
          cmd_o.op = OP_PREP;
          state_d  = ST_SUS;
        end else begin
          cmd_o.op = OP_ZERO;
          state_d  = ST_OUT;
        end
      end
      ST_SUS: begin cmd_o.op = OP_SUS; state_d = ST_EA; end
      ST_EA: begin
        cmd_o.op = status_i.rel_lt_a ? OP_MUL_A : OP_SUB_A;
        state_d  = status_i.rel_lt_a ? ST_EMUL : ST_ED;
      end
      ST_ED: begin
        cmd_o.op = status_i.rel_lt_d ? OP_MUL_D : OP_SUB_D;
        state_d  = status_i.rel_lt_d ? ST_EMUL : ST_ES;
      end
      ST_ES: begin
        cmd_o.op = status_i.rel_lt_s ? OP_ENV_S : OP_SUB_S;
        state_d  = status_i.rel_lt_s ? ST_TDIV : ST_ER;
      end
      ST_ER: begin
        cmd_o.op = status_i.rel_lt_r ? OP_MUL_R : OP_ENV_Z;
        state_d  = status_i.rel_lt_r ? ST_EMUL : ST_TDIV;
      end
      ST_EMUL: begin cmd_o.op = OP_DIV_ENV; state_d = ST_EWAIT; end
      ST_EWAIT: if (status_i.div_done) begin cmd_o.op = OP_ENV_SET; state_d = ST_TDIV; end
      ST_TDIV: begin cmd_o.op = OP_DIV_T; state_d = ST_TWAIT; end
      ST_TWAIT: if (status_i.div_done) begin cmd_o.op = OP_SET_T; state_d = ST_WAVE; end
      ST_WAVE: begin
        if (status_i.shape == SHAPE_SQUARE) begin
          cmd_o.op = OP_SQR;
          state_d  = ST_OUT;
        end else begin
          cmd_o.op = OP_MUL_W;
          state_d  = ST_WDIV;
        end
      end
      ST_WDIV: begin cmd_o.op = OP_DIV_W; state_d = ST_WWAIT; end
      ST_WWAIT: if (status_i.div_done) begin cmd_o.op = OP_SET_V; state_d = ST_SMUL; end
      ST_SMUL: begin cmd_o.op = OP_MUL_SC; state_d = ST_SDIV; end
      ST_SDIV: begin cmd_o.op = OP_SET_RES; state_d = ST_OUT; end
      ST_OUT: if (out_free) begin cmd_o.op = OP_EMIT; state_d = ST_IDLE; end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/adsr_waveform_generator_unit.sv =====
// enveloped waveform generator: one 16-bit sample per input word
// input channel: in_valid_i / in_stall_o with restart_i; restart_i high
//   plays sample zero of the note, low plays the next sample
// output channel: out_valid_o / out_stall_i with sample_o, note_active_o
//   and last_of_note_o; once the note is over the block returns zero samples
//   with note_active_o low and the sample index holds
// configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (shape, period, attack, decay, sustain percent, release, note length);
//   the user must write only while the block is idle, which the block does
//   not enforce; unknown indexes are dropped
// divisions by the 34-bit restoring divider set how long a word takes:
//   envelope ramp (none while sustaining or silent), wave phase and, except
//   for square, wave value; sustain level and gain use reciprocals; a word
//   past the note end needs no division
// one word at a time: the next word can be taken in the cycle after the last
//   one is loaded into the output register
// a stalled receiver holds the word and the block waits before loading it
// reset: clears the sample index, loads the default note settings and
//   empties the output register
`timescale 1ns / 1ps
`default_nettype none

module adsr_waveform_generator_unit
  import awg_pkg::*;
#(
  parameter int unsigned IndexBits      = 20,
  parameter int unsigned SineTableDepth = 256
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  restart_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic signed [15:0]         sample_o,
  output logic                       note_active_o,
  output logic                       last_of_note_o
);

  // command and status between sequencer and datapath
  awg_cmd_t    cmd;
  awg_status_t status;

  awg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // config registers, envelope/wave arithmetic, divider and output word
  awg_dp #(
    .IndexBits     (IndexBits),
    .SineTableDepth(SineTableDepth)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .restart_i     (restart_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .sample_o      (sample_o),
    .note_active_o (note_active_o),
    .last_of_note_o(last_of_note_o)
  );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import awg_pkg::*;

  localparam logic [2:0] CFG_UNUSED = 3'd7;   // index with no register behind it
  localparam int unsigned TABLE_DEPTH = 256;
  localparam longint FULL = 32767;
  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned SETTLE_CYCLES = 250;  // longer than one word's latency

  typedef struct packed {
    logic signed [15:0] sample;
    logic               active;
    logic               last;
  } note_word_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  restart_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [15:0]    sample_o;
  logic                  note_active_o;
  logic                  last_of_note_o;

  adsr_waveform_generator_unit DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .restart_i,
    .out_valid_o, .out_stall_i, .sample_o, .note_active_o, .last_of_note_o
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // predictor copy of the note settings and the sample index
  logic [1:0]  shape_q = SHAPE_SQUARE;
  logic [15:0] period_q = 16'd100;
  logic [15:0] attack_q = 16'd480;
  logic [15:0] decay_q = 16'd480;
  logic [6:0]  sustain_q = 7'd50;
  logic [15:0] release_q = 16'd480;
  logic [19:0] note_len_q = 20'd2400;
  logic [19:0] index_q = '0;
  longint      sine_rom [TABLE_DEPTH];

  logic        pending_restart [$];   // words waiting for the driver
  note_word_t  expected_words [$];
  int          errors = 0;
  int          words_sent = 0;
  int          words_checked = 0;
  int          restarts_sent = 0;
  int          setting_count = 0;
  int          send_gap = 0;
  int          recv_gap = 0;

  // quarter-wave sine in q30 through a truncated taylor series
  function automatic longint quarter_sine(longint num);
    longint x, term, sum;
    x = (num * HALF_PI_Q30) / TABLE_DEPTH;
    term = x;
    sum = x;
    for (int k = 1; k <= 6; k++) begin
      term = (term * x) >>> 30;
      term = (term * x) >>> 30;
      term = term / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    if (sum < 0) sum = 0;
    sum = (sum * FULL + (64'd1 << 29)) >>> 30;
    if (sum > FULL) sum = FULL;
    return sum;
  endfunction

  initial begin
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      int quad, rem;
      quad = (4 * k) / TABLE_DEPTH;
      rem = (4 * k) % TABLE_DEPTH;
      sine_rom[k] = quarter_sine(quad % 2 ? TABLE_DEPTH - rem : rem);
      if (quad >= 2) sine_rom[k] = -sine_rom[k];
    end
  end

  function automatic longint adsr_gain(longint n, longint len);
    longint a, d, r, pct, s, sus_len;
    a = attack_q;
    d = decay_q;
    r = release_q;
    pct = sustain_q > 100 ? 100 : sustain_q;
    s = pct * FULL / 100;
    sus_len = (len > a + d + r) ? len - (a + d + r) : 0;
    if (n < a) return n * FULL / a;
    n = n - a;
    if (n < d) return FULL - n * (FULL - s) / d;
    n = n - d;
    if (n < sus_len) return s;
    n = n - sus_len;
    if (n < r) return s - n * s / r;
    return 0;
  endfunction

  function automatic longint apply_gain(longint gain, longint v);
    longint mag;
    mag = v < 0 ? -v : v;
    return v < 0 ? -(gain * mag / FULL) : gain * mag / FULL;
  endfunction

  // works out the word for one input and, while the note is active, advances the sample index
  function automatic note_word_t next_note_word(logic restart);
    note_word_t w;
    longint len, p, n, t, gain, v, smp;
    len = note_len_q;
    p = period_q < 2 ? 2 : period_q;
    if (restart) index_q = '0;
    n = index_q;
    smp = 0;
    w.active = n < len;
    if (w.active) begin
      gain = adsr_gain(n, len);
      t = n % p;
      case (awg_shape_e'(shape_q))
        SHAPE_SQUARE: smp = (t < p / 2) ? gain : -gain;
        SHAPE_SAW: begin
          v = 2 * t * FULL / p;
          if (v >= FULL) v = v - 2 * FULL;
          smp = apply_gain(gain, v);
        end
        SHAPE_TRI: begin
          v = 4 * t * FULL / p;
          if (v >= FULL && v < 3 * FULL) v = 2 * FULL - v;
          else if (v >= 3 * FULL) v = v - 4 * FULL;
          smp = apply_gain(gain, v);
        end
        default: smp = apply_gain(gain, sine_rom[(t * TABLE_DEPTH / p) % TABLE_DEPTH]);
      endcase
      index_q = n + 1;
    end
    w.sample = smp[15:0];
    w.last = w.active && (n + 1 == len);
    return w;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // register writes land in the predictor at the same edge as in the block
  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) begin
      case (cfg_index_i)
        CFG_SHAPE:   shape_q <= cfg_data_i[1:0];
        CFG_PERIOD:  period_q <= cfg_data_i[15:0];
        CFG_ATTACK:  attack_q <= cfg_data_i[15:0];
        CFG_DECAY:   decay_q <= cfg_data_i[15:0];
        CFG_SUSTAIN: sustain_q <= cfg_data_i[6:0];
        CFG_RELEASE: release_q <= cfg_data_i[15:0];
        CFG_NOTE:    note_len_q <= cfg_data_i[19:0];
        default: ;   // unknown index, dropped
      endcase
    end
  end

  // driver: feeds words with restart flags from the pending queue, with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      restart_i <= 1'b0;
    end else begin
      logic busy;
      busy = in_valid_i && in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        expected_words.push_back(next_note_word(restart_i));
        words_sent++;
        if (restart_i) restarts_sent++;
        send_gap = pick_gap();
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_restart.size() > 0) begin
          in_valid_i <= 1'b1;
          restart_i <= pending_restart.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: random stalls, every accepted word checked against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word count", 1, 0);
        end else begin
          note_word_t want;
          want = expected_words.pop_front();
          words_checked++;
          if (sample_o !== want.sample) report_mismatch("sample", sample_o, want.sample);
          if (note_active_o !== want.active)
            report_mismatch("note_active", note_active_o, want.active);
          if (last_of_note_o !== want.last)
            report_mismatch("last_of_note", last_of_note_o, want.last);
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else begin
        recv_gap = pick_gap();
        out_stall_i <= recv_gap > 0;
      end
    end
  end

  task automatic wait_idle();
    while (pending_restart.size() > 0 || expected_words.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one register write per edge; caller lowers the enable after the batch
  task automatic write_reg(logic [2:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic load_note(int shape, int period, int atk, int dec, int sus, int rel,
                           int len);
    wait_idle();
    write_reg(CFG_SHAPE, CFG_DATA_W'(shape));
    write_reg(CFG_PERIOD, CFG_DATA_W'(period));
    write_reg(CFG_ATTACK, CFG_DATA_W'(atk));
    write_reg(CFG_DECAY, CFG_DATA_W'(dec));
    write_reg(CFG_SUSTAIN, CFG_DATA_W'(sus));
    write_reg(CFG_RELEASE, CFG_DATA_W'(rel));
    write_reg(CFG_NOTE, CFG_DATA_W'(len));
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
    setting_count++;
  endtask

  task automatic queue_words(int count, bit first_restart);
    for (int i = 0; i < count; i++)
      pending_restart.push_back(i == 0 ? first_restart : ($urandom_range(0, 15) == 0));
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: default note, then the corner settings
    queue_words(4, 1'b1);
    pending_restart.push_back(1'b1);
    load_note(SHAPE_SAW, 1, 0, 0, 127, 0, 0);     // empty note, period below two
    queue_words(3, 1'b1);
    load_note(SHAPE_TRI, 0, 0, 0, 100, 0, 1);     // single sample note
    queue_words(3, 1'b1);
    load_note(SHAPE_SINE, 65535, 65535, 65535, 0, 65535, 20'hFFFFF);
    queue_words(4, 1'b0);
    load_note(SHAPE_SQUARE, 2, 1, 1, 0, 1, 5);    // attack, decay and release one sample each, sustain two
    queue_words(7, 1'b1);

    // random notes, kept short so they run to the end and past it
    while (words_sent < 525) begin
      load_note($urandom_range(0, 3),
                $urandom_range(0, 7) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 40),
                $urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(0, 127),
                $urandom_range(0, 12), $urandom_range(0, 40));
      queue_words(10, 1'b1);
      wait_idle();   // sender holds until every word is back
      queue_words($urandom_range(5, 25), $urandom_range(0, 1));
    end

    wait_idle();
    $display("%0d words checked over %0d note settings, %0d of them restarts",
             words_checked, setting_count, restarts_sent);
    if (errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout, %0d words still expected", expected_words.size());
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
